FILE: rtl/lfds_pkg.sv
package lfds_pkg;

  // field widths
  localparam int unsigned SpeedW   = 10;
  localparam int unsigned TimeW    = 16;
  localparam int unsigned ClassW   = 4;
  localparam int unsigned DirW     = 2;
  localparam int unsigned PhaseW   = 3;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [SpeedW-1:0] SpeedMax = {SpeedW{1'b1}};

  // motor drive codes
  typedef enum logic [DirW-1:0] {
    DIR_STOP = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_BACK = 2'd2
  } dir_e;

  // sequencer phases
  localparam logic [PhaseW-1:0] PH_RUN      = 3'd0;
  localparam logic [PhaseW-1:0] PH_STRAIGHT = 3'd1;
  localparam logic [PhaseW-1:0] PH_PIVOT    = 3'd2;
  localparam logic [PhaseW-1:0] PH_SEEK     = 3'd3;

  // track classes
  localparam logic [ClassW-1:0] CLS_NONE     = 4'd0;
  localparam logic [ClassW-1:0] CLS_SLIGHT_L = 4'd1;
  localparam logic [ClassW-1:0] CLS_SLIGHT_R = 4'd2;
  localparam logic [ClassW-1:0] CLS_FAR_L    = 4'd3;
  localparam logic [ClassW-1:0] CLS_FAR_R    = 4'd4;
  localparam logic [ClassW-1:0] CLS_RECT_L   = 4'd5;
  localparam logic [ClassW-1:0] CLS_RECT_R   = 4'd6;
  localparam logic [ClassW-1:0] CLS_BOTH     = 4'd7;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_BASE_L     = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_BASE_R     = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_SPEED_STEP = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_MAX_BOOST  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_TURN_L     = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_TURN_R     = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_STRAIGHT   = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_PIVOT      = 3'd7;

  typedef struct packed {
    logic [SpeedW-1:0] base_left_speed;
    logic [SpeedW-1:0] base_right_speed;
    logic [SpeedW-1:0] speed_step;
    logic [SpeedW-1:0] max_boost;
    logic [SpeedW-1:0] turn_left_speed;
    logic [SpeedW-1:0] turn_right_speed;
    logic [TimeW-1:0]  straight_ms;
    logic [TimeW-1:0]  pivot_ms;
  } cfg_t;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic [SpeedW-1:0] cur_left_speed;
    logic [SpeedW-1:0] cur_right_speed;
    logic [TimeW-1:0]  phase_timer;
    logic              turning_left;
    dir_e              left_dir;
    dir_e              right_dir;
    logic              halt_latch;
  } state_t;

  typedef struct packed {
    logic [SpeedW-1:0] left_speed;
    logic [SpeedW-1:0] right_speed;
    logic [DirW-1:0]   left_drive;
    logic [DirW-1:0]   right_drive;
    logic              halted;
  } result_t;

  localparam cfg_t CfgReset = '{
    base_left_speed:  10'd150,
    base_right_speed: 10'd150,
    speed_step:       10'd10,
    max_boost:        10'd50,
    turn_left_speed:  10'd140,
    turn_right_speed: 10'd140,
    straight_ms:      16'd0,
    pivot_ms:         16'd0
  };

  localparam state_t StateReset = '{
    phase:           PH_RUN,
    cur_left_speed:  10'd150,
    cur_right_speed: 10'd150,
    phase_timer:     16'd0,
    turning_left:    1'b0,
    left_dir:        DIR_STOP,
    right_dir:       DIR_STOP,
    halt_latch:      1'b0
  };

endpackage

FILE: rtl/lfds_if.sv
// sample channel into the sequencer
interface lfds_in_if;
  import lfds_pkg::*;

  logic              valid;
  logic              ready;
  logic [ClassW-1:0] track_class;

  modport source (output valid, output track_class, input ready);
  modport sink (input valid, input track_class, output ready);
endinterface

// motor command channel out of the sequencer
interface lfds_out_if;
  import lfds_pkg::*;

  logic              valid;
  logic              ready;
  logic [SpeedW-1:0] left_speed;
  logic [SpeedW-1:0] right_speed;
  logic [DirW-1:0]   left_drive;
  logic [DirW-1:0]   right_drive;
  logic              halted;

  modport source (output valid, output left_speed, output right_speed,
                  output left_drive, output right_drive, output halted, input ready);
  modport sink (input valid, input left_speed, input right_speed,
                input left_drive, input right_drive, input halted, output ready);
endinterface

FILE: rtl/lfds_step.sv
module lfds_step #(
  parameter bit          TEST_MODE = 1'b0,
  parameter int unsigned TICK_MS   = 10
) (
  input  lfds_pkg::cfg_t                 cfg_i,
  input  lfds_pkg::state_t               state_i,
  input  logic [lfds_pkg::ClassW-1:0]    track_class_i,
  output lfds_pkg::state_t               state_o,
  output lfds_pkg::result_t              result_o
);
  import lfds_pkg::*;

  localparam logic [TimeW-1:0] TickVal = TimeW'(TICK_MS);

  logic [SpeedW:0]   lim_l;
  logic [SpeedW:0]   lim_r;
  logic              far;
  logic [SpeedW+1:0] step_amt;
  logic [SpeedW+1:0] sum_l;
  logic [SpeedW+1:0] sum_r;
  logic [SpeedW-1:0] sat_l;
  logic [SpeedW-1:0] sat_r;
  logic [TimeW-1:0]  tick_dn;
  logic              rect_left;
  state_t            nxt;

  // steering limits and raised speeds
  always_comb begin
    lim_l    = {1'b0, cfg_i.max_boost} + {1'b0, cfg_i.base_left_speed};
    lim_r    = {1'b0, cfg_i.max_boost} + {1'b0, cfg_i.base_right_speed};
    far      = (track_class_i == CLS_FAR_L) || (track_class_i == CLS_FAR_R);
    step_amt = far ? {1'b0, cfg_i.speed_step, 1'b0} : {2'b00, cfg_i.speed_step};
    sum_l    = {2'b00, state_i.cur_left_speed} + step_amt;
    sum_r    = {2'b00, state_i.cur_right_speed} + step_amt;
    sat_l    = (sum_l > {2'b00, SpeedMax}) ? SpeedMax : sum_l[SpeedW-1:0];
    sat_r    = (sum_r > {2'b00, SpeedMax}) ? SpeedMax : sum_r[SpeedW-1:0];
    tick_dn  = (state_i.phase_timer > TickVal) ? state_i.phase_timer - TickVal : '0;
  end

  // next state for one sample
  always_comb begin
    nxt       = state_i;
    rect_left = (track_class_i == CLS_RECT_L);
    if (!TEST_MODE && !state_i.halt_latch) begin
      case (state_i.phase)
        PH_STRAIGHT: begin
          if (track_class_i == CLS_BOTH) begin
            nxt.halt_latch = 1'b1;
            nxt.left_dir   = DIR_STOP;
            nxt.right_dir  = DIR_STOP;
            nxt.phase      = PH_RUN;
          end else begin
            nxt.phase_timer = tick_dn;
            if (tick_dn == '0) begin
              nxt.left_dir    = state_i.turning_left ? DIR_BACK : DIR_FWD;
              nxt.right_dir   = state_i.turning_left ? DIR_FWD : DIR_BACK;
              nxt.phase_timer = cfg_i.pivot_ms;
              nxt.phase       = (cfg_i.pivot_ms != '0) ? PH_PIVOT : PH_SEEK;
            end
          end
        end
        PH_PIVOT: begin
          nxt.phase_timer = tick_dn;
          if (tick_dn == '0) begin
            nxt.phase = PH_SEEK;
          end
        end
        PH_SEEK: begin
          if (track_class_i inside {CLS_NONE, CLS_SLIGHT_L, CLS_SLIGHT_R}) begin
            nxt.left_dir  = DIR_FWD;
            nxt.right_dir = DIR_FWD;
            nxt.phase     = PH_RUN;
          end
        end
        default: begin
          nxt.phase     = PH_RUN;
          nxt.left_dir  = DIR_FWD;
          nxt.right_dir = DIR_FWD;
          case (track_class_i)
            CLS_NONE: begin
              nxt.cur_left_speed  = cfg_i.base_left_speed;
              nxt.cur_right_speed = cfg_i.base_right_speed;
            end
            CLS_SLIGHT_L, CLS_FAR_L: begin
              if ({1'b0, state_i.cur_left_speed} < lim_l) begin
                nxt.cur_left_speed  = sat_l;
                nxt.cur_right_speed = cfg_i.turn_right_speed;
              end
            end
            CLS_SLIGHT_R, CLS_FAR_R: begin
              if ({1'b0, state_i.cur_right_speed} < lim_r) begin
                nxt.cur_right_speed = sat_r;
                nxt.cur_left_speed  = cfg_i.turn_left_speed;
              end
            end
            CLS_RECT_L, CLS_RECT_R: begin
              // right angle: straight first, or pivot at once on a zero time
              nxt.left_dir     = state_i.left_dir;
              nxt.right_dir    = state_i.right_dir;
              nxt.turning_left = rect_left;
              nxt.phase_timer  = cfg_i.straight_ms;
              if (cfg_i.straight_ms != '0) begin
                nxt.phase = PH_STRAIGHT;
              end else begin
                nxt.left_dir    = rect_left ? DIR_BACK : DIR_FWD;
                nxt.right_dir   = rect_left ? DIR_FWD : DIR_BACK;
                nxt.phase_timer = cfg_i.pivot_ms;
                nxt.phase       = (cfg_i.pivot_ms != '0) ? PH_PIVOT : PH_SEEK;
              end
            end
            CLS_BOTH: begin
              nxt.halt_latch = 1'b1;
              nxt.left_dir   = DIR_STOP;
              nxt.right_dir  = DIR_STOP;
            end
            default: begin
              // unknown class keeps speeds and drives forward
            end
          endcase
        end
      endcase
    end
  end

  // motor command from the updated state (base speeds forward in test mode)
  always_comb begin
    if (nxt.halt_latch) begin
      result_o.left_speed  = '0;
      result_o.right_speed = '0;
      result_o.left_drive  = DIR_STOP;
      result_o.right_drive = DIR_STOP;
      result_o.halted      = 1'b1;
    end else if (TEST_MODE) begin
      result_o.left_speed  = cfg_i.base_left_speed;
      result_o.right_speed = cfg_i.base_right_speed;
      result_o.left_drive  = DIR_FWD;
      result_o.right_drive = DIR_FWD;
      result_o.halted      = 1'b0;
    end else begin
      result_o.left_speed  = nxt.cur_left_speed;
      result_o.right_speed = nxt.cur_right_speed;
      result_o.left_drive  = nxt.left_dir;
      result_o.right_drive = nxt.right_dir;
      result_o.halted      = 1'b0;
    end
  end

  assign state_o = nxt;

endmodule

FILE: rtl/line_follow_drive_sequencer_core.sv
// Line-follow drive sequencer.
// Samples come in on in_i, one track class per item; each sample gives exactly
// one motor command item on out_o (two speeds, two drive codes, halted flag).
// Settings are written on cfg_we_i / cfg_idx_i / cfg_wdata_i, by the user only
// while no sample is in flight (not enforced); they apply to the next sample.
// Path: an accepted sample is held in the sample register; its command is then
// registered in the command register and shown as valid on out_o.
// Throughput: one sample per cycle while out_o is not held, set by the single
// steering/timer update between the sample register and the command register.
// Reset: settings return to their default values, the sequencer goes to the
// run phase with base speeds and stopped drives, and no item is pending.
// Stall: while out_o is held, one more sample is taken into the sample
// register; after that in_i.ready drops until the command is taken.
// A both-sides mark latches a halt that only reset clears.
module line_follow_drive_sequencer_core #(
  parameter bit          TEST_MODE = 1'b0,
  parameter int unsigned TICK_MS   = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  lfds_in_if.sink                       in_i,
  lfds_out_if.source                    out_o,
  input  logic                          cfg_we_i,
  input  logic [lfds_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lfds_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import lfds_pkg::*;

  cfg_t              cfg_q;
  state_t            state_q;
  state_t            state_d;
  result_t           res_q;
  result_t           res_d;
  logic              in_valid_q;
  logic [ClassW-1:0] cls_q;
  logic              out_valid_q;
  logic              advance;

  // an item moves to the output when the output slot is free or being taken
  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BASE_L:     cfg_q.base_left_speed  <= cfg_wdata_i[SpeedW-1:0];
        CFG_BASE_R:     cfg_q.base_right_speed <= cfg_wdata_i[SpeedW-1:0];
        CFG_SPEED_STEP: cfg_q.speed_step       <= cfg_wdata_i[SpeedW-1:0];
        CFG_MAX_BOOST:  cfg_q.max_boost        <= cfg_wdata_i[SpeedW-1:0];
        CFG_TURN_L:     cfg_q.turn_left_speed  <= cfg_wdata_i[SpeedW-1:0];
        CFG_TURN_R:     cfg_q.turn_right_speed <= cfg_wdata_i[SpeedW-1:0];
        CFG_STRAIGHT:   cfg_q.straight_ms      <= cfg_wdata_i[TimeW-1:0];
        CFG_PIVOT:      cfg_q.pivot_ms         <= cfg_wdata_i[TimeW-1:0];
        default: begin
        end
      endcase
    end
  end

  // sample register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      cls_q <= in_i.track_class;
    end
  end

  // steering and sequence update
  lfds_step #(
    .TEST_MODE (TEST_MODE),
    .TICK_MS   (TICK_MS)
  ) u_step (
    .cfg_i         (cfg_q),
    .state_i       (state_q),
    .track_class_i (cls_q),
    .state_o       (state_d),
    .result_o      (res_d)
  );

  // sequencer state and command valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StateReset;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        state_q <= state_d;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // command register
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.left_speed  = res_q.left_speed;
  assign out_o.right_speed = res_q.right_speed;
  assign out_o.left_drive  = res_q.left_drive;
  assign out_o.right_drive = res_q.right_drive;
  assign out_o.halted      = res_q.halted;

endmodule

FILE: rtl/lfds_checker.sv
module lfds_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [lfds_pkg::SpeedW-1:0] out_left_speed,
  input logic [lfds_pkg::SpeedW-1:0] out_right_speed,
  input logic [lfds_pkg::DirW-1:0]   out_left_drive,
  input logic [lfds_pkg::DirW-1:0]   out_right_drive,
  input logic                        out_halted
);
  import lfds_pkg::*;

  logic [1:0] pending_q;
  logic       seen_halt_q;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // items taken but whose command is not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q   <= '0;
      seen_halt_q <= 1'b0;
    end else begin
      pending_q <= pending_q + {1'b0, in_acc} - {1'b0, out_acc};
      if (out_acc && out_halted) begin
        seen_halt_q <= 1'b1;
      end
    end
  end

  // a command waits until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("command dropped before it was taken");

  // never a command without a sample, never more than two in flight
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid |-> pending_q != 2'd0) && pending_q != 2'd3)
    else $error("command count does not match samples");

  // halt sticks until reset
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && seen_halt_q |-> out_halted)
    else $error("halt released without reset");

  // halted command stops both motors
  a_halt_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_halted |-> out_left_speed == '0 && out_right_speed == '0
      && out_left_drive == DIR_STOP && out_right_drive == DIR_STOP)
    else $error("halted command still drives a motor");

  // drive code is one of stop, forward, backward
  a_drive_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_left_drive != 2'd3 && out_right_drive != 2'd3)
    else $error("illegal drive code");

endmodule

bind line_follow_drive_sequencer_core lfds_checker u_lfds_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid        (in_i.valid),
  .in_ready        (in_i.ready),
  .out_valid       (out_o.valid),
  .out_ready       (out_o.ready),
  .out_left_speed  (out_o.left_speed),
  .out_right_speed (out_o.right_speed),
  .out_left_drive  (out_o.left_drive),
  .out_right_drive (out_o.right_drive),
  .out_halted      (out_o.halted)
);
